FILE: design/humidity_frame_check_convert_assert.svh
// Assertion macros used by the checker file hfcc_checker.sv.
`ifndef HUMIDITY_FRAME_CHECK_CONVERT_ASSERT_SVH
`define HUMIDITY_FRAME_CHECK_CONVERT_ASSERT_SVH

// Same-cycle implication, sampled on aclk, off while reset is low.
`define HFCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while reset is low.
`define HFCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hfcc_pkg.sv
`timescale 1ns / 1ps

package hfcc_pkg;

    localparam int RAW_W   = 16;
    localparam int SPAN_W  = 11;
    localparam int PROD_W  = RAW_W + SPAN_W;
    localparam int QUO_W   = PROD_W - RAW_W;
    localparam int RES_W   = 12;
    localparam int STAT_W  = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hff;

    localparam logic [SPAN_W-1:0] TEMP_SPAN = SPAN_W'(1750);
    localparam logic [SPAN_W-1:0] HUM_SPAN  = SPAN_W'(1250);
    localparam logic [RES_W-1:0]  TEMP_OFFSET = RES_W'(450);
    localparam logic [RES_W-1:0]  HUM_OFFSET  = RES_W'(60);
    localparam logic [RAW_W:0]    DIVISOR     = (RAW_W + 1)'(17'h0ffff);

    localparam logic signed [RES_W-1:0] TEMP_MIN = -12'sd450;
    localparam logic signed [RES_W-1:0] TEMP_MAX = 12'sd1300;
    localparam logic signed [RES_W-1:0] HUM_MIN  = -12'sd60;
    localparam logic signed [RES_W-1:0] HUM_MAX  = 12'sd1190;

    localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_CRC  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FAIL = 2'd2;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [RAW_W-1:0]  temp_raw;
        logic [RAW_W-1:0]  hum_raw;
    } job_t;

endpackage

FILE: design/humidity_frame_check_convert.sv
`timescale 1ns / 1ps
// Takes one frame byte per cycle while the result queue has room; a frame of six bytes gives one result.
// The result shows on m_valid after the last byte (or a failed transfer) is accepted,
// passing the result queue, the multiplier stage and the output register in turn.
// Throughput: one byte per cycle and one result per cycle while the result queue has room and m_ready is high.
// Reset (aresetn low, synchronous) clears frame position, queue and pipe valid bits.
module humidity_frame_check_convert #(
    parameter int QUEUE_DEPTH = hfcc_pkg::QUEUE_DEPTH
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    input  logic                                s_frame_start,
    input  logic                                s_transfer_failed,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [hfcc_pkg::RES_W-1:0]   m_temperature_tenths,
    output logic signed [hfcc_pkg::RES_W-1:0]   m_humidity_tenths,
    output logic        [hfcc_pkg::STAT_W-1:0]  m_frame_status
);

    logic           fq_valid, fq_ready;
    hfcc_pkg::job_t fq_job;
    logic           qb_valid, qb_ready;
    hfcc_pkg::job_t qb_job;

    hfcc_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_rx_byte         (s_rx_byte),
        .s_frame_start     (s_frame_start),
        .s_transfer_failed (s_transfer_failed),
        .job_valid         (fq_valid),
        .job_ready         (fq_ready),
        .job               (fq_job)
    );

    hfcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_job    (fq_job),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_job   (qb_job)
    );

    hfcc_back u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .job_valid            (qb_valid),
        .job_ready            (qb_ready),
        .job                  (qb_job),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths),
        .m_frame_status       (m_frame_status)
    );

endmodule

FILE: design/hfcc_front.sv
`timescale 1ns / 1ps

module hfcc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_rx_byte,
    input  logic              s_frame_start,
    input  logic              s_transfer_failed,
    output logic              job_valid,
    input  logic              job_ready,
    output hfcc_pkg::job_t    job
);

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
        logic [7:0] c;
        c = crc_in ^ data;
        for (int b = 0; b < 8; b++) begin
            c = c[7] ? ((c << 1) ^ hfcc_pkg::CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    logic [2:0] pos_reg, pos_next, pos_eff;
    logic [7:0] crc_reg, crc_next;
    logic       t_ok_reg, t_ok_next;
    logic [7:0] t_hi_reg, t_hi_next;
    logic [7:0] t_lo_reg, t_lo_next;
    logic [7:0] h_hi_reg, h_hi_next;
    logic [7:0] h_lo_reg, h_lo_next;
    logic       accept;
    logic       h_ok;

    assign s_ready = job_ready;
    assign accept  = s_valid && s_ready;
    assign pos_eff = (s_frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
    assign h_ok    = (crc_reg == s_rx_byte);

    always_comb begin
        crc_next  = crc_reg;
        t_ok_next = t_ok_reg;
        t_hi_next = t_hi_reg;
        t_lo_next = t_lo_reg;
        h_hi_next = h_hi_reg;
        h_lo_next = h_lo_reg;
        unique case (pos_eff)
            POS_T_HI: begin
                t_hi_next = s_rx_byte;
                crc_next  = crc8_byte(hfcc_pkg::CRC_INIT, s_rx_byte);
            end
            POS_T_LO: begin
                t_lo_next = s_rx_byte;
                crc_next  = crc8_byte(crc_reg, s_rx_byte);
            end
            POS_T_CRC: begin
                t_ok_next = (crc_reg == s_rx_byte);
            end
            POS_H_HI: begin
                h_hi_next = s_rx_byte;
                crc_next  = crc8_byte(hfcc_pkg::CRC_INIT, s_rx_byte);
            end
            POS_H_LO: begin
                h_lo_next = s_rx_byte;
                crc_next  = crc8_byte(crc_reg, s_rx_byte);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            if (s_transfer_failed || pos_eff == POS_H_CRC) begin
                pos_next = POS_T_HI;
            end else begin
                pos_next = pos_eff + 3'd1;
            end
        end
    end

    // A result leaves the front on a failed transfer or on the last byte of a frame.
    assign job_valid = s_valid && (s_transfer_failed || pos_eff == POS_H_CRC);

    always_comb begin
        job.temp_raw = {t_hi_reg, t_lo_reg};
        job.hum_raw  = {h_hi_reg, h_lo_reg};
        if (s_transfer_failed) begin
            job.status = hfcc_pkg::STATUS_FAIL;
        end else if (t_ok_reg && h_ok) begin
            job.status = hfcc_pkg::STATUS_OK;
        end else begin
            job.status = hfcc_pkg::STATUS_CRC;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= POS_T_HI;
        end else begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && !s_transfer_failed) begin
            crc_reg  <= crc_next;
            t_ok_reg <= t_ok_next;
            t_hi_reg <= t_hi_next;
            t_lo_reg <= t_lo_next;
            h_hi_reg <= h_hi_next;
            h_lo_reg <= h_lo_next;
        end
    end

endmodule

FILE: design/hfcc_queue.sv
`timescale 1ns / 1ps

module hfcc_queue #(
    parameter int DEPTH = hfcc_pkg::QUEUE_DEPTH
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  hfcc_pkg::job_t in_job,
    output logic           out_valid,
    input  logic           out_ready,
    output hfcc_pkg::job_t out_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hfcc_pkg::job_t entry_reg [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_job   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_job;
        end
    end

endmodule

FILE: design/hfcc_back.sv
`timescale 1ns / 1ps

module hfcc_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  hfcc_pkg::job_t                      job,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [hfcc_pkg::RES_W-1:0]   m_temperature_tenths,
    output logic signed [hfcc_pkg::RES_W-1:0]   m_humidity_tenths,
    output logic        [hfcc_pkg::STAT_W-1:0]  m_frame_status
);

    // floor(prod / 65535) with prod < 2^27: estimate by the top bits, then one correction.
    function automatic logic [hfcc_pkg::RES_W-1:0] scale(
        input logic [hfcc_pkg::PROD_W-1:0] prod,
        input logic [hfcc_pkg::RES_W-1:0]  offset
    );
        logic [hfcc_pkg::QUO_W-1:0] q0;
        logic [hfcc_pkg::RAW_W:0]   rem;
        logic [hfcc_pkg::QUO_W-1:0] q;
        q0  = prod[hfcc_pkg::PROD_W-1:hfcc_pkg::RAW_W];
        rem = {1'b0, prod[hfcc_pkg::RAW_W-1:0]} + (hfcc_pkg::RAW_W + 1)'(q0);
        q   = q0 + hfcc_pkg::QUO_W'(rem >= hfcc_pkg::DIVISOR);
        return hfcc_pkg::RES_W'(q) - offset;
    endfunction

    logic                          advance;
    logic                          s1_valid_reg;
    logic [hfcc_pkg::STAT_W-1:0]   s1_status_reg;
    logic [hfcc_pkg::PROD_W-1:0]   t_prod_reg, t_prod_next;
    logic [hfcc_pkg::PROD_W-1:0]   h_prod_reg, h_prod_next;
    logic                          out_valid_reg;
    logic [hfcc_pkg::RES_W-1:0]    temp_reg, temp_next;
    logic [hfcc_pkg::RES_W-1:0]    hum_reg, hum_next;
    logic [hfcc_pkg::STAT_W-1:0]   status_reg;

    // Advance the whole pipe unless the output holds a result that is not taken.
    assign advance   = !out_valid_reg || m_ready;
    assign job_ready = advance;

    assign t_prod_next = hfcc_pkg::PROD_W'(job.temp_raw) * hfcc_pkg::PROD_W'(hfcc_pkg::TEMP_SPAN);
    assign h_prod_next = hfcc_pkg::PROD_W'(job.hum_raw) * hfcc_pkg::PROD_W'(hfcc_pkg::HUM_SPAN);

    always_comb begin
        if (s1_status_reg == hfcc_pkg::STATUS_OK) begin
            temp_next = scale(t_prod_reg, hfcc_pkg::TEMP_OFFSET);
            hum_next  = scale(h_prod_reg, hfcc_pkg::HUM_OFFSET);
        end else begin
            temp_next = '0;
            hum_next  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg  <= job_valid;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_status_reg <= job.status;
            t_prod_reg    <= t_prod_next;
            h_prod_reg    <= h_prod_next;
            temp_reg      <= temp_next;
            hum_reg       <= hum_next;
            status_reg    <= s1_status_reg;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_temperature_tenths = $signed(temp_reg);
    assign m_humidity_tenths    = $signed(hum_reg);
    assign m_frame_status       = status_reg;

endmodule

FILE: design/hfcc_checker.sv
`timescale 1ns / 1ps
`include "humidity_frame_check_convert_assert.svh"

module hfcc_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [hfcc_pkg::RES_W-1:0]   m_temperature_tenths,
    input logic signed [hfcc_pkg::RES_W-1:0]   m_humidity_tenths,
    input logic        [hfcc_pkg::STAT_W-1:0]  m_frame_status
);

    logic                                            ok_result;
    logic                                            bad_result;
    logic                                            stalled;
    logic [2*hfcc_pkg::RES_W+hfcc_pkg::STAT_W-1:0]   result_bits;
    logic                                            values_zero;
    logic                                            temp_in_range;
    logic                                            hum_in_range;

    assign ok_result   = m_valid && (m_frame_status == hfcc_pkg::STATUS_OK);
    assign bad_result  = m_valid && (m_frame_status != hfcc_pkg::STATUS_OK);
    assign stalled     = m_valid && !m_ready;
    assign result_bits = {m_temperature_tenths, m_humidity_tenths, m_frame_status};
    assign values_zero = (m_temperature_tenths == '0) && (m_humidity_tenths == '0);

    assign temp_in_range = (m_temperature_tenths >= hfcc_pkg::TEMP_MIN) &&
                           (m_temperature_tenths <= hfcc_pkg::TEMP_MAX);
    assign hum_in_range  = (m_humidity_tenths >= hfcc_pkg::HUM_MIN) &&
                           (m_humidity_tenths <= hfcc_pkg::HUM_MAX);

    // Hold a stalled result.
    `HFCC_ASSERT_NEXT(a_out_hold, stalled, m_valid && $stable(result_bits), "held result changed")

    `HFCC_ASSERT_NOW(a_status_zero, bad_result, values_zero, "status result carries nonzero values")

    `HFCC_ASSERT_NOW(a_temp_range, ok_result, temp_in_range, "temperature out of range")

    `HFCC_ASSERT_NOW(a_hum_range, ok_result, hum_in_range, "humidity out of range")

endmodule

bind humidity_frame_check_convert hfcc_checker u_checker (.*);

FILE: sim/frame_result_checker.sv
`timescale 1ns / 1ps

package hfcc_tb_pkg;

    // CRC-8 over a 16-bit word, MSB first, one bit per step
    function automatic logic [7:0] crc8_of_word(input logic [15:0] word);
        logic [7:0] crc;
        crc = hfcc_pkg::CRC_INIT;
        for (int i = 15; i >= 0; i--) begin
            if (crc[7] ^ word[i]) begin
                crc = {crc[6:0], 1'b0} ^ hfcc_pkg::CRC_POLY;
            end else begin
                crc = {crc[6:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

module frame_result_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [7:0]                          s_rx_byte,
    input  logic                                s_frame_start,
    input  logic                                s_transfer_failed,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [hfcc_pkg::RES_W-1:0]   m_temperature_tenths,
    input  logic signed [hfcc_pkg::RES_W-1:0]   m_humidity_tenths,
    input  logic        [hfcc_pkg::STAT_W-1:0]  m_frame_status,
    output int                                  mismatches,
    output int                                  outstanding
);

    localparam int unsigned TEMP_RANGE = 1750;
    localparam int unsigned TEMP_BIAS  = 450;
    localparam int unsigned HUM_RANGE  = 1250;
    localparam int unsigned HUM_BIAS   = 60;
    localparam int unsigned FULL_SCALE = 32'hffff;
    localparam int          LAST_POS   = 5;

    typedef struct packed {
        logic signed [hfcc_pkg::RES_W-1:0]  temp;
        logic signed [hfcc_pkg::RES_W-1:0]  hum;
        logic        [hfcc_pkg::STAT_W-1:0] status;
    } reading_t;

    reading_t   expected_readings[$];
    reading_t   want;
    logic [2:0] next_pos;
    logic [7:0] held_bytes [0:4];

    initial begin
        mismatches  = 0;
        outstanding = 0;
        next_pos    = '0;
    end

    function automatic logic signed [hfcc_pkg::RES_W-1:0] to_tenths(input logic [15:0] raw,
                                                                    input int unsigned span,
                                                                    input int unsigned bias);
        int unsigned q;
        q = (span * raw) / FULL_SCALE;
        return hfcc_pkg::RES_W'(q - bias);
    endfunction

    task automatic report(input string msg);
        $display("checker @%0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // Advance the frame position and queue the reading this byte completes, if any
    task automatic take_byte(input logic [7:0] rx, input logic start, input logic failed);
        logic [2:0]  pos;
        logic [15:0] t_word;
        logic [15:0] h_word;
        reading_t    r;
        if (failed) begin
            next_pos = '0;
            r = '{temp: '0, hum: '0, status: hfcc_pkg::STATUS_FAIL};
            expected_readings.push_back(r);
        end else begin
            pos = (start || next_pos > LAST_POS) ? 3'd0 : next_pos;
            if (pos < LAST_POS) begin
                held_bytes[pos] = rx;
                next_pos = pos + 3'd1;
            end else begin
                next_pos = '0;
                t_word = {held_bytes[0], held_bytes[1]};
                h_word = {held_bytes[3], held_bytes[4]};
                if (hfcc_tb_pkg::crc8_of_word(t_word) != held_bytes[2] ||
                    hfcc_tb_pkg::crc8_of_word(h_word) != rx) begin
                    r = '{temp: '0, hum: '0, status: hfcc_pkg::STATUS_CRC};
                end else begin
                    r = '{temp: to_tenths(t_word, TEMP_RANGE, TEMP_BIAS),
                          hum: to_tenths(h_word, HUM_RANGE, HUM_BIAS),
                          status: hfcc_pkg::STATUS_OK};
                end
                expected_readings.push_back(r);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            next_pos = '0;
            expected_readings.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_readings.size() == 0) begin
                    report($sformatf("result with no frame pending, status %0d",
                                     m_frame_status));
                end else begin
                    want = expected_readings.pop_front();
                    if (m_frame_status !== want.status) begin
                        report($sformatf("status %0d, expected %0d",
                                         m_frame_status, want.status));
                    end
                    if (m_temperature_tenths !== want.temp) begin
                        report($sformatf("temperature %0d, expected %0d",
                                         m_temperature_tenths, $signed(want.temp)));
                    end
                    if (m_humidity_tenths !== want.hum) begin
                        report($sformatf("humidity %0d, expected %0d",
                                         m_humidity_tenths, $signed(want.hum)));
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_byte(s_rx_byte, s_frame_start, s_transfer_failed);
            end
        end
        outstanding = expected_readings.size();
    end

endmodule

FILE: sim/humidity_frame_check_convert_tb.sv
`timescale 1ns / 1ps

module humidity_frame_check_convert_tb;

    localparam int TARGET_BYTES = 950;
    localparam int HOLD_CYCLES  = 400;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [7:0]                         s_rx_byte;
    logic                               s_frame_start;
    logic                               s_transfer_failed;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [hfcc_pkg::RES_W-1:0]  m_temperature_tenths;
    logic signed [hfcc_pkg::RES_W-1:0]  m_humidity_tenths;
    logic        [hfcc_pkg::STAT_W-1:0] m_frame_status;

    int mismatch_count;
    int readings_pending;
    int sent_bytes     = 0;
    int taken_readings = 0;
    bit hold_off       = 1'b0;

    humidity_frame_check_convert dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .s_frame_start        (s_frame_start),
        .s_transfer_failed    (s_transfer_failed),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths),
        .m_frame_status       (m_frame_status)
    );

    frame_result_checker result_watch (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_rx_byte            (s_rx_byte),
        .s_frame_start        (s_frame_start),
        .s_transfer_failed    (s_transfer_failed),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_temperature_tenths (m_temperature_tenths),
        .m_humidity_tenths    (m_humidity_tenths),
        .m_frame_status       (m_frame_status),
        .mismatches           (mismatch_count),
        .outstanding          (readings_pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #3ms;
        $display("tb: failure");
        $finish;
    end

    // Offer one byte after a random gap and hold it until the transfer
    task automatic put_byte(input logic [7:0] rx, input logic start, input logic failed);
        int gap;
        gap = (hold_off || sent_bytes % 128 >= 96) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_rx_byte         = rx;
        s_frame_start     = start;
        s_transfer_failed = failed;
        s_valid           = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_bytes++;
        @(negedge aclk);
    endtask

    task automatic put_frame(input logic [15:0] t_raw, input logic [15:0] h_raw,
                             input logic start0, input logic [7:0] t_flip,
                             input logic [7:0] h_flip);
        put_byte(t_raw[15:8], start0, 1'b0);
        put_byte(t_raw[7:0], 1'b0, 1'b0);
        put_byte(hfcc_tb_pkg::crc8_of_word(t_raw) ^ t_flip, 1'b0, 1'b0);
        put_byte(h_raw[15:8], 1'b0, 1'b0);
        put_byte(h_raw[7:0], 1'b0, 1'b0);
        put_byte(hfcc_tb_pkg::crc8_of_word(h_raw) ^ h_flip, 1'b0, 1'b0);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // Result side: random stalls per reading, with two long hold-offs to back up the block
    initial begin
        int stall;
        m_ready = 1'b0;
        @(negedge aclk);
        while (!aresetn) @(negedge aclk);
        forever begin
            if (taken_readings == 20 || taken_readings == 100) begin
                hold_off = 1'b1;
                m_ready  = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off = 1'b0;
            end
            stall = (taken_readings % 32 >= 24) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken_readings++;
            @(negedge aclk);
        end
    end

    initial begin
        int          kind;
        int          n;
        logic [15:0] t_raw;
        logic [15:0] h_raw;
        logic        start0;
        logic [7:0]  t_flip;
        logic [7:0]  h_flip;
        bit          aligned;

        aresetn           = 1'b0;
        s_valid           = 1'b0;
        s_rx_byte         = '0;
        s_frame_start     = 1'b0;
        s_transfer_failed = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // scale extremes, back-to-back frames with and without a start mark
        put_frame(16'h0000, 16'hffff, 1'b1, 8'h00, 8'h00);
        put_frame(16'hffff, 16'h0000, 1'b0, 8'h00, 8'h00);
        // restart mid-frame, then a bad temperature CRC
        put_byte(8'h5a, 1'b1, 1'b0);
        put_frame(16'h1234, 16'hbeef, 1'b1, 8'h01, 8'h00);
        // failed transfer mid-frame, start and byte ignored
        put_byte(8'h00, 1'b1, 1'b0);
        put_byte(8'h7e, 1'b1, 1'b1);
        // bad humidity CRC
        put_frame(16'h6666, 16'h8000, 1'b1, 8'h00, 8'h80);

        aligned = 1'b1;
        while (sent_bytes < TARGET_BYTES) begin
            kind   = $urandom_range(0, 99);
            start0 = aligned ? 1'($urandom_range(0, 1)) : 1'b1;
            t_raw  = pick_raw();
            h_raw  = pick_raw();
            if (kind < 70) begin
                put_frame(t_raw, h_raw, start0, 8'h00, 8'h00);
                aligned = 1'b1;
            end else if (kind < 80) begin
                t_flip = 8'h00;
                h_flip = 8'h00;
                n = $urandom_range(0, 2);
                if (n != 1) t_flip = 8'($urandom_range(1, 255));
                if (n != 0) h_flip = 8'($urandom_range(1, 255));
                put_frame(t_raw, h_raw, start0, t_flip, h_flip);
                aligned = 1'b1;
            end else if (kind < 88) begin
                // truncated frame; the next one restarts mid-frame
                n = $urandom_range(1, 5);
                for (int i = 0; i < n; i++) begin
                    put_byte(8'($urandom), (i == 0) ? start0 : 1'b0, 1'b0);
                end
                aligned = 1'b0;
            end else if (kind < 95) begin
                n = $urandom_range(0, 5);
                for (int i = 0; i < n; i++) begin
                    put_byte(8'($urandom), (i == 0) ? start0 : 1'b0, 1'b0);
                end
                put_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
                aligned = 1'b1;
            end else begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) begin
                    put_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
                end
                aligned = 1'b0;
            end
        end
        s_valid = 1'b0;

        while (readings_pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: humidity_frame_check_convert.f
+incdir+design
design/hfcc_pkg.sv
design/hfcc_front.sv
design/hfcc_queue.sv
design/hfcc_back.sv
design/humidity_frame_check_convert.sv
design/hfcc_checker.sv
sim/frame_result_checker.sv
sim/humidity_frame_check_convert_tb.sv
